### rtl/icb_pkg.sv
`default_nettype none
package icb_pkg;

  localparam int BUFFER_DEPTH = 1024;
  localparam int MAX_DRAIN    = 64;

  localparam int ADDR_W  = $clog2(BUFFER_DEPTH);
  localparam int COUNT_W = ADDR_W + 1;
  localparam int DRAIN_W = $clog2(MAX_DRAIN + 1);

  // Fixed field widths
  localparam int OP_W    = 2;
  localparam int BYTE_W  = 8;
  localparam int TIME_W  = 32;
  localparam int LIM_W   = 7;
  localparam int PEND_W  = 11;
  localparam int IDLE_W  = 16;
  localparam int CMP_W   = (COUNT_W > LIM_W) ? COUNT_W : LIM_W;

  localparam logic [IDLE_W-1:0] IDLE_RESET = 16'd8;

  localparam logic [BYTE_W-1:0] CH_ETX = 8'h03;
  localparam logic [BYTE_W-1:0] CH_EOT = 8'h04;
  localparam logic [BYTE_W-1:0] CH_ESC = 8'h1b;
  localparam logic [BYTE_W-1:0] CH_CR  = 8'h0d;
  localparam logic [BYTE_W-1:0] CH_LF  = 8'h0a;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 2'd0,
    OP_CHECK = 2'd1,
    OP_DRAIN = 2'd2
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic accept;     // input beat taken this cycle
    logic drain_run;  // drain sequence in progress
  } ctrl_cmd_t;

  typedef struct packed {
    logic res_space;   // result queue can take a beat
    logic drain_start; // current input is a drain that moves bytes
    logic drain_done;  // final byte of the drain enters the queue
  } dp_status_t;

  typedef struct packed {
    logic              accepted;
    logic              flush_due;
    logic [BYTE_W-1:0] out_byte;
    logic              out_valid;
    logic              last;
    logic [PEND_W-1:0] pending_count;
  } result_t;

  function automatic logic is_urgent(input logic [BYTE_W-1:0] b);
    return (b == CH_CR) || (b == CH_LF) || (b == CH_ETX) || (b == CH_EOT) ||
           (b == CH_ESC);
  endfunction

endpackage
`default_nettype wire

### rtl/input_coalescing_buffer_core.sv
`default_nettype none
// Keystroke coalescing buffer with idle flush.
// Slave stream: one beat is one command. tuser carries the op code (push,
// check, drain); tdata carries data_byte, now_time and drain_limit.
// Master stream: one or more result beats per command, tlast on the final
// one; tuser flags a beat that carries a drained byte.
// Push and check: the result is offered in the cycle after the command is
// taken; a new command can be taken every cycle while the receiver keeps up.
// Drain of n bytes (n = min(held, drain_limit, 64)): each byte is read
// through the single registered read port of the byte store, then written
// to the result queue, one byte per cycle while the queue has space; the
// next command waits for the last byte to enter the result queue. An empty
// drain gives one empty beat with tlast.
// Reset clears pointers, count, force flag and last push time, and loads
// the idle limit with 8 ms. The store contents need no clearing.
// A stalled receiver fills a two-entry result queue; the drain pauses and
// new commands wait until a queue slot frees up. Writes of zero to the idle
// limit are ignored.
module input_coalescing_buffer_core (
  input  wire        clk,
  input  wire        rst,
  input  wire        cfg_we,
  input  wire [15:0] cfg_wdata,   // idle_limit
  input  wire        s_tvalid,
  output logic       s_tready,
  input  wire [47:0] s_tdata,     // data_byte[7:0], now_time[39:8], drain_limit[46:40]
  input  wire [1:0]  s_tuser,     // op[1:0]
  output logic       m_tvalid,
  input  wire        m_tready,
  output logic [23:0] m_tdata,    // accepted[0], flush_due[1], out_byte[9:2],
                                  // pending_count[20:10]
  output logic       m_tuser,     // out_valid
  output logic       m_tlast      // last
);
  import icb_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t sts;
  result_t    res;

  // Sequence commands: idle vs. drain in progress
  icb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Store, counters, flush decision and result queue
  icb_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .op          (s_tuser),
    .data_byte   (s_tdata[7:0]),
    .now_time    (s_tdata[39:8]),
    .drain_limit (s_tdata[46:40]),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .res_valid   (m_tvalid),
    .res_ready   (m_tready),
    .res         (res)
  );

  assign m_tdata = {3'b000, res.pending_count, res.out_byte, res.flush_due, res.accepted};
  assign m_tuser = res.out_valid;
  assign m_tlast = res.last;

endmodule
`default_nettype wire

### rtl/icb_ctrl.sv
`default_nettype none
module icb_ctrl (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    s_tvalid,
  output logic                   s_tready,
  input  icb_pkg::dp_status_t    sts,
  output icb_pkg::ctrl_cmd_t     cmd
);
  import icb_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid && s_tready && sts.drain_start) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (sts.drain_done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready      = 1'b0;
    cmd.drain_run = 1'b0;
    case (state)
      ST_IDLE:  s_tready = sts.res_space;
      ST_DRAIN: cmd.drain_run = 1'b1;
      default: begin
        s_tready      = 1'b0;
        cmd.drain_run = 1'b0;
      end
    endcase
    cmd.accept = s_tvalid && s_tready;
  end

endmodule
`default_nettype wire

### rtl/icb_datapath.sv
`default_nettype none
module icb_datapath (
  input  wire                           clk,
  input  wire                           rst,
  input  icb_pkg::ctrl_cmd_t            cmd,
  output icb_pkg::dp_status_t           sts,
  input  wire [icb_pkg::OP_W-1:0]       op,
  input  wire [icb_pkg::BYTE_W-1:0]     data_byte,
  input  wire [icb_pkg::TIME_W-1:0]     now_time,
  input  wire [icb_pkg::LIM_W-1:0]      drain_limit,
  input  wire                           cfg_we,
  input  wire [icb_pkg::IDLE_W-1:0]     cfg_wdata,
  output logic                          res_valid,
  input  wire                           res_ready,
  output icb_pkg::result_t              res
);
  import icb_pkg::*;

  logic [BYTE_W-1:0]  byte_store [BUFFER_DEPTH];
  logic [ADDR_W-1:0]  read_pointer;
  logic [COUNT_W-1:0] fill_count;
  logic [TIME_W-1:0]  last_push_time;
  logic               force_flag;
  logic [IDLE_W-1:0]  idle_limit;

  // Drain sequencer
  logic [DRAIN_W-1:0] remain;
  logic [BYTE_W-1:0]  rd_data;
  logic               rd_valid;
  logic               rd_last;

  // Two-entry result queue
  result_t            rq [2];
  logic               rq_wp;
  logic               rq_rp;
  logic [1:0]         rq_cnt;

  op_t                op_c;
  logic               not_full;
  logic [COUNT_W-1:0] fill_push;
  logic [LIM_W-1:0]   lim_c;
  logic [CMP_W-1:0]   n_cmp;
  logic [DRAIN_W-1:0] n_drain;
  logic [ADDR_W-1:0]  write_pointer;
  logic [TIME_W-1:0]  gap;
  logic               due;
  logic               rd_issue;
  logic               byte_wr;
  logic               res_wr;
  logic               res_pop;
  result_t            res_in;

  assign op_c          = op_t'(op);
  assign not_full      = fill_count < COUNT_W'(BUFFER_DEPTH);
  assign fill_push     = fill_count + COUNT_W'(not_full);
  assign write_pointer = read_pointer + fill_count[ADDR_W-1:0];
  assign lim_c         = (drain_limit > LIM_W'(MAX_DRAIN)) ? LIM_W'(MAX_DRAIN) : drain_limit;
  assign n_cmp         = (CMP_W'(fill_count) < CMP_W'(lim_c)) ? CMP_W'(fill_count)
                                                               : CMP_W'(lim_c);
  assign n_drain       = DRAIN_W'(n_cmp);
  assign gap           = now_time - last_push_time;
  assign due           = (fill_count != '0) &&
                         (force_flag || !not_full ||
                          ((now_time >= last_push_time) && (gap >= TIME_W'(idle_limit))));

  assign sts.res_space   = rq_cnt != 2'd2;
  assign sts.drain_start = (op_c == OP_DRAIN) && (n_drain != '0);
  assign byte_wr         = rd_valid && sts.res_space;
  assign sts.drain_done  = byte_wr && rd_last;
  assign rd_issue        = cmd.drain_run && (remain != '0) && (!rd_valid || byte_wr);

  always_comb begin
    res_wr = 1'b0;
    res_in = '0;
    if (cmd.accept) begin
      res_in.last          = 1'b1;
      res_in.pending_count = PEND_W'(fill_count);
      case (op_c)
        OP_PUSH: begin
          res_wr               = 1'b1;
          res_in.accepted      = not_full;
          res_in.pending_count = PEND_W'(fill_push);
        end
        OP_CHECK: begin
          res_wr           = 1'b1;
          res_in.flush_due = due;
        end
        OP_DRAIN: res_wr = (n_drain == '0);
        default:  res_wr = 1'b1;
      endcase
    end else if (byte_wr) begin
      res_wr               = 1'b1;
      res_in.out_byte      = rd_data;
      res_in.out_valid     = 1'b1;
      res_in.last          = rd_last;
      res_in.pending_count = PEND_W'(fill_count);
    end
  end

  // Byte store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.accept && (op_c == OP_PUSH) && not_full) begin
      byte_store[write_pointer] <= data_byte;
    end
    if (rd_issue) begin
      rd_data <= byte_store[read_pointer];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_pointer   <= '0;
      fill_count     <= '0;
      last_push_time <= '0;
      force_flag     <= 1'b0;
      idle_limit     <= IDLE_RESET;
      remain         <= '0;
      rd_valid       <= 1'b0;
      rd_last        <= 1'b0;
    end else begin
      if (cfg_we && (cfg_wdata != '0)) begin
        idle_limit <= cfg_wdata;
      end
      if (cmd.accept) begin
        case (op_c)
          OP_PUSH: begin
            last_push_time <= now_time;
            fill_count     <= fill_push;
            if (not_full && is_urgent(data_byte)) begin
              force_flag <= 1'b1;
            end
          end
          OP_DRAIN: begin
            if (n_drain != '0) begin
              remain     <= n_drain;
              fill_count <= fill_count - COUNT_W'(n_drain);
              if (fill_count == COUNT_W'(n_drain)) begin
                force_flag <= 1'b0;
              end
            end
          end
          default: ;
        endcase
      end
      if (rd_issue) begin
        read_pointer <= read_pointer + ADDR_W'(1);
        remain       <= remain - DRAIN_W'(1);
        rd_last      <= remain == DRAIN_W'(1);
        rd_valid     <= 1'b1;
      end else if (byte_wr) begin
        rd_valid <= 1'b0;
      end
    end
  end

  assign res_valid = rq_cnt != 2'd0;
  assign res_pop   = res_valid && res_ready;
  assign res       = rq[rq_rp];

  always_ff @(posedge clk) begin
    if (res_wr) begin
      rq[rq_wp] <= res_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rq_wp  <= 1'b0;
      rq_rp  <= 1'b0;
      rq_cnt <= 2'd0;
    end else begin
      if (res_wr) begin
        rq_wp <= ~rq_wp;
      end
      if (res_pop) begin
        rq_rp <= ~rq_rp;
      end
      rq_cnt <= rq_cnt + {1'b0, res_wr} - {1'b0, res_pop};
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= COUNT_W'(BUFFER_DEPTH))
    else $error("fill count above buffer depth");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    rq_cnt != 2'd3)
    else $error("result queue overflow");

  a_accept_quiet: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |-> (!rd_valid && (remain == '0)))
    else $error("input taken while a drain is still running");

  a_drain_end: assert property (@(posedge clk) disable iff (rst)
    sts.drain_done |=> (!rd_valid && (remain == '0)))
    else $error("drain ended with bytes still in flight");

endmodule
`default_nettype wire
